### design/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define CCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CCD_NEVER(label, clk, rst_n, cond, msg) \
    `CCD_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### design/ccd_pkg.sv
package ccd_pkg;

    localparam int MASK_W          = 8;
    localparam int TIME_W          = 32;
    localparam int TICKS_W         = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int MAX_EVENTS      = 3;
    localparam int EV_COUNT_W      = 2;
    localparam int CONTROL_BUTTONS_DEF = 8;

    localparam logic [TICKS_W-1:0] LONG_HOLD_RESET = 16'd500;
    localparam logic [TICKS_W-1:0] SETTLE_RESET    = 16'd50;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SPECIAL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SPECIAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HOLD      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE         = 2'd3;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [MASK_W-1:0] button_mask;
        logic [TIME_W-1:0] time_now;
        logic              long_combos_enabled;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [MASK_W-1:0] event_mask;
        logic              final_event;
    } out_beat_t;

    typedef struct packed {
        logic [MASK_W-1:0]  first_special_mask;
        logic [MASK_W-1:0]  second_special_mask;
        logic [TICKS_W-1:0] long_hold_ticks;
        logic [TICKS_W-1:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic              suppress_until_release;
        logic [MASK_W-1:0] hold_mask;
        logic [TIME_W-1:0] hold_since;
        logic              hold_long_fired;
        logic [MASK_W-1:0] candidate_mask;
        logic [TIME_W-1:0] candidate_since;
        logic [MASK_W-1:0] last_fired_mask;
        logic [MASK_W-1:0] consumed_members;
    } det_state_t;

    typedef struct packed {
        ev_kind_t          kind;
        logic [MASK_W-1:0] mask;
    } ev_t;

    typedef struct packed {
        ev_t [MAX_EVENTS-1:0]  ev;
        logic [EV_COUNT_W-1:0] count;
    } ev_list_t;

endpackage

### design/ccd_step.sv
// Next-state and event logic for one button snapshot.
module ccd_step #(
    parameter int CONTROL_BUTTONS = ccd_pkg::CONTROL_BUTTONS_DEF
) (
    input  ccd_pkg::cfg_t       cfg,
    input  ccd_pkg::det_state_t cur,
    input  ccd_pkg::in_beat_t   beat,
    output ccd_pkg::det_state_t nxt,
    output ccd_pkg::ev_list_t   events
);

    localparam logic [ccd_pkg::MASK_W-1:0] BUTTON_VALID =
        ccd_pkg::MASK_W'((ccd_pkg::MASK_W+1)'(1) << CONTROL_BUTTONS) - 1'b1;

    logic [ccd_pkg::MASK_W-1:0] mask;
    logic [ccd_pkg::TIME_W-1:0] now;
    logic                       multi;
    logic                       long_combo;
    logic                       hold_special;
    logic                       all_down;
    logic                       done;
    logic [ccd_pkg::TIME_W-1:0] hold_elapsed;
    logic [ccd_pkg::TIME_W-1:0] cand_elapsed;

    assign mask = beat.button_mask & BUTTON_VALID;
    assign now  = beat.time_now;

    always_comb
    begin
        multi        = (mask != '0) && ((mask & (mask - 1'b1)) != '0);
        long_combo   = beat.long_combos_enabled &&
                       ((mask == cfg.first_special_mask) ||
                        (mask == cfg.second_special_mask));
        hold_special = (cur.hold_mask == cfg.first_special_mask) ||
                       (cur.hold_mask == cfg.second_special_mask);
        all_down     = (mask & cur.hold_mask) == cur.hold_mask;
        done         = 1'b0;
        hold_elapsed = '0;
        cand_elapsed = '0;

        nxt           = cur;
        events        = '0;
        events.ev     = '0;
        events.count  = '0;

        if (multi)
        begin
            nxt.consumed_members = cur.consumed_members | mask;
        end

        if (cur.suppress_until_release)
        begin
            // wait for all buttons up, then rearm
            if (mask == '0)
            begin
                nxt.suppress_until_release = 1'b0;
                nxt.hold_mask       = '0;
                nxt.candidate_mask  = '0;
                nxt.candidate_since = '0;
                nxt.last_fired_mask = '0;
            end
        end
        else
        begin
            if (mask != cur.hold_mask)
            begin
                if (hold_special)
                begin
                    if (!all_down)
                    begin
                        // special combo let go: press before release unless the long press already fired
                        if (!cur.hold_long_fired)
                        begin
                            events.ev[events.count] = '{ccd_pkg::EV_PRESS, cur.hold_mask};
                            events.count = events.count + 1'b1;
                        end
                        events.ev[events.count] = '{ccd_pkg::EV_RELEASE, cur.hold_mask};
                        events.count = events.count + 1'b1;
                    end
                    else if (cur.hold_long_fired)
                    begin
                        // extra buttons on a fired long combo: ignore the snapshot
                        done = 1'b1;
                    end
                end
                if (!done)
                begin
                    nxt.hold_mask       = long_combo ? mask : '0;
                    nxt.hold_since      = now;
                    nxt.hold_long_fired = 1'b0;
                end
            end

            if (!done)
            begin
                hold_elapsed = now - nxt.hold_since;
                if (long_combo && !nxt.hold_long_fired &&
                    (hold_elapsed >= ccd_pkg::TIME_W'(cfg.long_hold_ticks)))
                begin
                    nxt.hold_long_fired  = 1'b1;
                    nxt.consumed_members = nxt.consumed_members | mask;
                    events.ev[events.count] = '{ccd_pkg::EV_LONG, mask};
                    events.count = events.count + 1'b1;
                end

                if (multi && !long_combo)
                begin
                    if (mask != cur.candidate_mask)
                    begin
                        nxt.candidate_mask  = mask;
                        nxt.candidate_since = now;
                    end
                    cand_elapsed = now - nxt.candidate_since;
                    if ((mask != cur.last_fired_mask) &&
                        (cand_elapsed >= ccd_pkg::TIME_W'(cfg.settle_ticks)))
                    begin
                        events.ev[events.count] = '{ccd_pkg::EV_PRESS, mask};
                        events.count = events.count + 1'b1;
                        nxt.last_fired_mask        = mask;
                        nxt.suppress_until_release = 1'b1;
                    end
                end
                else
                begin
                    nxt.candidate_mask  = '0;
                    nxt.candidate_since = '0;
                    nxt.last_fired_mask = mask;
                end
            end
        end
    end

endmodule

### design/chord_combo_detector_top.sv
// Chord combo detector. Each in_data beat is a snapshot of held buttons with a
// millisecond time stamp; out_data beats are combo press, release and long-press
// events, with final_event set on the last event of each snapshot. A snapshot
// goes from the input register through one pass of detection logic into a
// three-entry result register, from which its events are offered once the
// snapshot has advanced into it. One snapshot is taken per cycle as long as
// each yields at most one event and the receiver does not stall; a snapshot
// that yields k events (k up to 3) keeps the result register until the single
// output channel has drained it, one beat per cycle while out_stall is low.
// Snapshots with no event pass through without using an output cycle.
// Configuration writes must only happen while no snapshot is in flight.
`include "assert_macros.svh"

module chord_combo_detector_top #(
    parameter int CONTROL_BUTTONS = ccd_pkg::CONTROL_BUTTONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [ccd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  ccd_pkg::in_beat_t               in_data,

    output logic                            out_valid,
    input  logic                            out_stall,
    output ccd_pkg::out_beat_t              out_data
);

    // configuration registers
    ccd_pkg::cfg_t       cfg_reg;

    // input register
    logic                in_valid_reg;
    ccd_pkg::in_beat_t   in_reg;

    // detector state
    ccd_pkg::det_state_t state_reg;
    ccd_pkg::det_state_t state_next;

    // result register: up to three events, drained one beat at a time
    ccd_pkg::ev_t [ccd_pkg::MAX_EVENTS-1:0] ev_reg;
    logic [ccd_pkg::EV_COUNT_W-1:0]         ev_cnt_reg;
    logic [ccd_pkg::EV_COUNT_W-1:0]         ev_ptr_reg;

    ccd_pkg::ev_list_t   step_events;
    logic                taking;
    logic                last_take;
    logic                res_free;
    logic                advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_special_mask  <= '0;
            cfg_reg.second_special_mask <= '0;
            cfg_reg.long_hold_ticks     <= ccd_pkg::LONG_HOLD_RESET;
            cfg_reg.settle_ticks        <= ccd_pkg::SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ccd_pkg::CFG_FIRST_SPECIAL:
                    cfg_reg.first_special_mask  <= cfg_data[ccd_pkg::MASK_W-1:0];
                ccd_pkg::CFG_SECOND_SPECIAL:
                    cfg_reg.second_special_mask <= cfg_data[ccd_pkg::MASK_W-1:0];
                ccd_pkg::CFG_LONG_HOLD:
                    cfg_reg.long_hold_ticks     <= cfg_data[ccd_pkg::TICKS_W-1:0];
                ccd_pkg::CFG_SETTLE:
                    cfg_reg.settle_ticks        <= cfg_data[ccd_pkg::TICKS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    ccd_step #(
        .CONTROL_BUTTONS (CONTROL_BUTTONS)
    ) u_step (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .beat   (in_reg),
        .nxt    (state_next),
        .events (step_events)
    );

    // Handshake: the result register frees up when empty or when its last beat
    // leaves this cycle; the input register advances into it at that point.
    assign out_valid = (ev_cnt_reg != '0);
    assign taking    = out_valid && !out_stall;
    assign last_take = taking && (ev_ptr_reg == (ev_cnt_reg - 1'b1));
    assign res_free  = !out_valid || last_take;
    assign advance   = in_valid_reg && res_free;
    assign in_stall  = in_valid_reg && !res_free;

    assign out_data.event_kind  = ev_reg[ev_ptr_reg].kind;
    assign out_data.event_mask  = ev_reg[ev_ptr_reg].mask;
    assign out_data.final_event = (ev_ptr_reg == (ev_cnt_reg - 1'b1));

    // input register: load a new beat whenever not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    // detector state: advance once per snapshot as it enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_cnt_reg <= '0;
            ev_ptr_reg <= '0;
        end
        else if (advance)
        begin
            ev_cnt_reg <= step_events.count;
            ev_ptr_reg <= '0;
        end
        else if (last_take)
        begin
            ev_cnt_reg <= '0;
            ev_ptr_reg <= '0;
        end
        else if (taking)
        begin
            ev_ptr_reg <= ev_ptr_reg + 1'b1;
        end
    end

    // event payload: hold until the next snapshot lands
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg <= step_events.ev;
        end
    end

    `CCD_ASSERT(a_ptr_in_range, clk, rst_n, out_valid |-> (ev_ptr_reg < ev_cnt_reg),
        "result pointer beyond event count")
    `CCD_NEVER(a_stall_without_results, clk, rst_n, in_stall && !out_valid,
        "input stalled while result register is empty")
    `CCD_ASSERT(a_load_starts_at_first, clk, rst_n,
        (advance && (step_events.count != '0)) |=> (out_valid && (ev_ptr_reg == '0)),
        "loaded events do not start at the first beat")
    `CCD_ASSERT(a_hold_while_stalled, clk, rst_n,
        (in_valid_reg && in_stall) |=> (in_valid_reg && $stable(in_reg)),
        "input register changed while stalled")

endmodule

### tb/sv/chord_combo_detector_top_tb.sv
`timescale 1ns / 1ps

module chord_combo_detector_top_tb;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int FLUSH_CYCLES      = 8;    // two-stage pipe plus margin
    localparam int RX_HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT      = 10;
    localparam logic [ccd_pkg::MASK_W-1:0] BUTTON_KEEP =
        {ccd_pkg::MASK_W{1'b1}} >> (ccd_pkg::MASK_W - ccd_pkg::CONTROL_BUTTONS_DEF);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we = 1'b0;
    logic [ccd_pkg::CFG_INDEX_W-1:0] cfg_index = ccd_pkg::CFG_FIRST_SPECIAL;
    logic [ccd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    ccd_pkg::in_beat_t  in_data = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    ccd_pkg::out_beat_t out_data;

    chord_combo_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the detector registers and state
    logic [ccd_pkg::MASK_W-1:0]  special_a;
    logic [ccd_pkg::MASK_W-1:0]  special_b;
    logic [ccd_pkg::TICKS_W-1:0] long_hold_ms;
    logic [ccd_pkg::TICKS_W-1:0] settle_ms;

    logic                       chord_locked;
    logic [ccd_pkg::MASK_W-1:0] held_combo;
    logic [ccd_pkg::TIME_W-1:0] held_since;
    logic                       held_long_done;
    logic [ccd_pkg::MASK_W-1:0] cand_mask;
    logic [ccd_pkg::TIME_W-1:0] cand_since;
    logic [ccd_pkg::MASK_W-1:0] last_fired;
    logic [ccd_pkg::MASK_W-1:0] consumed_buttons;

    ccd_pkg::ev_t       step_events[$];
    ccd_pkg::out_beat_t due_events[$];
    ccd_pkg::out_beat_t next_due;

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          snapshots_sent = 0;
    logic [ccd_pkg::TIME_W-1:0] ms_clock = '0;

    // Idle shaping: calm_mode turns off gaps on both sides, tx_no_gaps only on the sender.
    logic calm_mode = 1'b0;
    logic tx_no_gaps = 1'b0;
    int   rx_hold_requests = 0;
    int   rx_hold_seen = 0;
    int   rx_hold_left = 0;
    int   rx_burst_left = 0;

    function automatic logic is_chord(logic [ccd_pkg::MASK_W-1:0] m);
        return (m != '0) && ((m & (m - 1'b1)) != '0);
    endfunction

    function automatic logic is_special_mask(logic [ccd_pkg::MASK_W-1:0] m);
        return (m == special_a) || (m == special_b);
    endfunction

    function automatic void reset_predictor();
        special_a        = '0;
        special_b        = '0;
        long_hold_ms     = ccd_pkg::LONG_HOLD_RESET;
        settle_ms        = ccd_pkg::SETTLE_RESET;
        chord_locked     = 1'b0;
        held_combo       = '0;
        held_since       = '0;
        held_long_done   = 1'b0;
        cand_mask        = '0;
        cand_since       = '0;
        last_fired       = '0;
        consumed_buttons = '0;
    endfunction

    function automatic void note_event(ccd_pkg::ev_kind_t kind,
                                       logic [ccd_pkg::MASK_W-1:0] mask);
        ccd_pkg::ev_t e;
        e.kind = kind;
        e.mask = mask;
        if (step_events.size() < ccd_pkg::MAX_EVENTS)
            step_events.push_back(e);
    endfunction

    // Work out the combo events one accepted snapshot causes and queue them.
    function automatic void predict_combo_events(ccd_pkg::in_beat_t beat);
        logic [ccd_pkg::MASK_W-1:0] mask;
        logic [ccd_pkg::TIME_W-1:0] now;
        logic [ccd_pkg::TIME_W-1:0] elapsed;
        logic                       chord;
        logic                       long_combo;
        logic                       all_down;
        logic                       done;
        ccd_pkg::out_beat_t         ev_beat;
        mask       = beat.button_mask & BUTTON_KEEP;
        now        = beat.time_now;
        chord      = is_chord(mask);
        long_combo = beat.long_combos_enabled && is_special_mask(mask);
        done       = 1'b0;
        step_events.delete();

        if (chord)
            consumed_buttons |= mask;

        // After a fired chord everything is ignored until all buttons are up.
        if (chord_locked)
        begin
            if (mask == '0)
            begin
                chord_locked = 1'b0;
                held_combo   = '0;
                cand_mask    = '0;
                cand_since   = '0;
                last_fired   = '0;
            end
            done = 1'b1;
        end

        if (!done && mask != held_combo)
        begin
            if (is_special_mask(held_combo))
            begin
                all_down = (mask & held_combo) == held_combo;
                if (!all_down)
                begin
                    if (!held_long_done)
                        note_event(ccd_pkg::EV_PRESS, held_combo);
                    note_event(ccd_pkg::EV_RELEASE, held_combo);
                end
                done = all_down && held_long_done;
            end
            if (!done)
            begin
                held_combo     = long_combo ? mask : '0;
                held_since     = now;
                held_long_done = 1'b0;
            end
        end

        if (!done)
        begin
            elapsed = now - held_since;
            if (long_combo && !held_long_done && elapsed >= {16'd0, long_hold_ms})
            begin
                held_long_done = 1'b1;
                consumed_buttons |= mask;
                note_event(ccd_pkg::EV_LONG, mask);
            end

            if (chord && !long_combo)
            begin
                if (mask != cand_mask)
                begin
                    cand_mask  = mask;
                    cand_since = now;
                end
                elapsed = now - cand_since;
                if (mask != last_fired && elapsed >= {16'd0, settle_ms})
                begin
                    note_event(ccd_pkg::EV_PRESS, mask);
                    last_fired   = mask;
                    chord_locked = 1'b1;
                end
            end
            else
            begin
                cand_mask  = '0;
                cand_since = '0;
                last_fired = mask;
            end
        end

        foreach (step_events[i])
        begin
            ev_beat.event_kind  = step_events[i].kind;
            ev_beat.event_mask  = step_events[i].mask;
            ev_beat.final_event = (i == step_events.size() - 1);
            due_events.push_back(ev_beat);
        end
    endfunction

    function automatic void flag_mismatch(string what, ccd_pkg::out_beat_t want,
                                          ccd_pkg::out_beat_t got);
        string want_s;
        string got_s;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            want_s = $sformatf("kind=%0d mask=%h final=%0b",
                               want.event_kind, want.event_mask, want.final_event);
            got_s  = $sformatf("kind=%0d mask=%h final=%0b",
                               got.event_kind, got.event_mask, got.final_event);
            $display("[%0t] %s: expected %s, got %s", $realtime, what, want_s, got_s);
        end
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Advance the millisecond clock, mostly around the given threshold, sometimes
    // by a huge step that wraps the counter.
    function automatic logic [ccd_pkg::TIME_W-1:0] tick_forward(int unsigned thr);
        int unsigned                r;
        logic [ccd_pkg::TIME_W-1:0] delta;
        r = $urandom_range(0, 99);
        if (r < 30)
            delta = $urandom_range(0, 10);
        else if (r < 70)
            delta = thr + $urandom_range(0, 4) - 2;
        else if (r < 95)
            delta = $urandom_range(0, 2 * thr + 1);
        else
            delta = $urandom;
        ms_clock += delta;
        return ms_clock;
    endfunction

    function automatic logic [ccd_pkg::MASK_W-1:0] random_chord();
        logic [ccd_pkg::MASK_W-1:0] m;
        do
            m = ccd_pkg::MASK_W'($urandom);
        while (!is_chord(m));
        return m;
    endfunction

    // Offer one snapshot beat, hold it until taken, then maybe idle a while.
    // Called at a falling edge; returns at a falling edge.
    task automatic send_snapshot(logic [ccd_pkg::MASK_W-1:0] mask,
                                 logic [ccd_pkg::TIME_W-1:0] stamp,
                                 logic enable);
        ccd_pkg::in_beat_t beat;
        int                gap;
        beat.button_mask         = mask;
        beat.time_now            = stamp;
        beat.long_combos_enabled = enable;
        in_data  = beat;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_combo_events(beat);
        snapshots_sent++;
        @(negedge clk);
        gap = (tx_no_gaps || calm_mode || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every queued event, then let the pipe empty out
    // (snapshots with no event may still be in flight).
    task automatic wait_for_quiet();
        in_valid = 1'b0;
        while (due_events.size() != 0)
            @(negedge clk);
        repeat (FLUSH_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [ccd_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [ccd_pkg::CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            ccd_pkg::CFG_FIRST_SPECIAL:  special_a    = value[ccd_pkg::MASK_W-1:0];
            ccd_pkg::CFG_SECOND_SPECIAL: special_b    = value[ccd_pkg::MASK_W-1:0];
            ccd_pkg::CFG_LONG_HOLD:      long_hold_ms = value;
            ccd_pkg::CFG_SETTLE:         settle_ms    = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Write all four registers while the block is idle. Junk goes in the unused
    // upper bits of the mask writes.
    task automatic set_config(logic [ccd_pkg::MASK_W-1:0] first_mask,
                              logic [ccd_pkg::MASK_W-1:0] second_mask,
                              logic [ccd_pkg::TICKS_W-1:0] long_ms,
                              logic [ccd_pkg::TICKS_W-1:0] settle);
        logic [ccd_pkg::CFG_DATA_W-1:0] junk;
        junk = ccd_pkg::CFG_DATA_W'($urandom);
        wait_for_quiet();
        write_register(ccd_pkg::CFG_FIRST_SPECIAL, {junk[15:8], first_mask});
        write_register(ccd_pkg::CFG_SECOND_SPECIAL, {junk[7:0], second_mask});
        write_register(ccd_pkg::CFG_LONG_HOLD, long_ms);
        write_register(ccd_pkg::CFG_SETTLE, settle);
        cfg_we = 1'b0;
    endtask

    // Reset register values: both special masks are zero, so the empty snapshot
    // counts as a long-hold combo when enabled.
    task automatic test_ordinary_chords();
        calm_mode = 1'b1;
        send_snapshot(8'h03, 32'd1000, 1'b0);
        send_snapshot(8'h03, 32'd1050, 1'b0);    // settled: press
        send_snapshot(8'h07, 32'd1100, 1'b0);    // suppressed
        send_snapshot(8'h00, 32'd1200, 1'b0);    // release clears suppression
        send_snapshot(8'hFF, 32'd2000, 1'b0);
        send_snapshot(8'h3C, 32'd2010, 1'b0);    // chord changes, restart settle
        send_snapshot(8'h3C, 32'd1000, 1'b1);    // time went backwards: wraps to elapsed
        send_snapshot(8'h00, 32'd1500, 1'b1);
        send_snapshot(8'h00, 32'd2500, 1'b1);    // zero special mask held long enough
        calm_mode = 1'b0;
    endtask

    task automatic test_long_hold_combos();
        set_config(8'h05, 8'hA0, 16'd100, 16'd20);
        calm_mode = 1'b1;
        send_snapshot(8'h05, 32'd10000, 1'b1);
        send_snapshot(8'h05, 32'd10120, 1'b1);   // long press
        send_snapshot(8'h07, 32'd10130, 1'b1);   // members still down after long press
        send_snapshot(8'h04, 32'd10140, 1'b1);   // partial release: release only
        send_snapshot(8'hA0, 32'd11000, 1'b1);
        send_snapshot(8'h00, 32'd11050, 1'b1);   // let go early: press then release
        calm_mode = 1'b0;
    endtask

    task automatic test_edge_values();
        // Same-step long press with a zero hold time, and the all-ones mask.
        set_config(8'hFF, 8'h00, 16'd0, 16'd0);
        calm_mode = 1'b1;
        send_snapshot(8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_snapshot(8'h00, 32'h0000_0000, 1'b1);   // release, then zero-mask long press
        send_snapshot(8'h00, 32'h0000_0001, 1'b1);

        // Three events from one snapshot: press, release and a new chord press.
        set_config(8'h81, 8'h42, 16'hFFFF, 16'd0);
        calm_mode = 1'b1;
        send_snapshot(8'h81, 32'd100, 1'b1);
        send_snapshot(8'h18, 32'd200, 1'b1);
        send_snapshot(8'h00, 32'd300, 1'b1);
        send_snapshot(8'h81, 32'd400, 1'b0);         // special mask but long combos off
        send_snapshot(8'h00, 32'd500, 1'b0);

        // Longest settle time: one short, then exactly on the limit.
        set_config(8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
        calm_mode = 1'b1;
        send_snapshot(8'h30, 32'd1000, 1'b0);
        send_snapshot(8'h30, 32'd66534, 1'b0);
        send_snapshot(8'h30, 32'd66535, 1'b0);
        send_snapshot(8'h00, 32'd70000, 1'b0);
        calm_mode = 1'b0;
    endtask

    // Mostly well-formed gestures: hold a chord or a special combo, vary it,
    // release it. The rest is noise.
    task automatic run_gestures(int count);
        int                         stop_at;
        int unsigned                r;
        int                         hold_len;
        logic [ccd_pkg::MASK_W-1:0] m;
        logic                       en;
        stop_at = snapshots_sent + count;
        while (snapshots_sent < stop_at)
        begin
            calm_mode = ($urandom_range(0, 9) == 0);
            en        = ($urandom_range(0, 7) != 0);
            r         = $urandom_range(0, 99);
            hold_len  = $urandom_range(1, 4);
            if (r < 35)
            begin
                m = random_chord();
                repeat (hold_len) send_snapshot(m, tick_forward(settle_ms), en);
                if ($urandom_range(0, 1))
                begin
                    m = random_chord();
                    repeat ($urandom_range(1, 2))
                        send_snapshot(m, tick_forward(settle_ms), en);
                end
                send_snapshot('0, tick_forward(settle_ms), en);
            end
            else if (r < 70)
            begin
                m = $urandom_range(0, 1) ? special_a : special_b;
                repeat (hold_len) send_snapshot(m, tick_forward(long_hold_ms), en);
                case ($urandom_range(0, 3))
                    0: send_snapshot(m | ccd_pkg::MASK_W'($urandom),
                                     tick_forward(long_hold_ms), en);
                    1: send_snapshot(m & ccd_pkg::MASK_W'($urandom),
                                     tick_forward(long_hold_ms), en);
                    2: send_snapshot(random_chord(), tick_forward(settle_ms), en);
                    default: ;
                endcase
                send_snapshot('0, tick_forward(long_hold_ms), en);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_snapshot(ccd_pkg::MASK_W'($urandom),
                                  tick_forward($urandom_range(0, 1) ? settle_ms : long_hold_ms),
                                  1'($urandom_range(0, 1)));
            end
        end
        calm_mode = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(8'h03, 8'h0C, 16'd500, 16'd50);
                1: set_config(random_chord(), random_chord(),
                              ccd_pkg::TICKS_W'($urandom_range(0, 200)),
                              ccd_pkg::TICKS_W'($urandom_range(0, 100)));
                2: set_config(8'h01 << $urandom_range(0, 7), 8'h00, 16'd0, 16'd0);
                3: set_config(ccd_pkg::MASK_W'($urandom), ccd_pkg::MASK_W'($urandom),
                              16'hFFFF, 16'hFFFF);
                default: set_config(ccd_pkg::MASK_W'($urandom), ccd_pkg::MASK_W'($urandom),
                                    ccd_pkg::TICKS_W'($urandom), ccd_pkg::TICKS_W'($urandom));
            endcase
            run_gestures(30);
        end
    endtask

    // Hold off the receiver for a long stretch while the sender keeps offering
    // beats, three in four producing an event, so the result register fills and the
    // input stalls. Between bursts the sender pauses until all events are in.
    task automatic test_backpressure();
        set_config(8'h05, 8'h50, 16'd0, 16'd0);
        tx_no_gaps = 1'b1;
        for (int burst = 0; burst < 2; burst++)
        begin
            rx_hold_requests++;
            for (int i = 0; i < 20; i++)
            begin
                case (i % 4)
                    0: send_snapshot(8'h05, tick_forward(0), 1'b1);   // long press at once
                    1: send_snapshot(8'h00, tick_forward(0), 1'b1);   // release
                    2: send_snapshot(8'h33, tick_forward(0), 1'b0);   // chord press
                    default: send_snapshot(8'h00, tick_forward(0), 1'b0);
                endcase
            end
            wait_for_quiet();
        end
        tx_no_gaps = 1'b0;
    endtask

    // Receiver: long hold-offs on request, otherwise random stall bursts.
    always @(negedge clk)
    begin
        if (rx_hold_seen != rx_hold_requests)
        begin
            rx_hold_seen = rx_hold_requests;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            out_stall = 1'b1;
            rx_hold_left--;
        end
        else if (rx_burst_left > 0)
        begin
            out_stall = 1'b1;
            rx_burst_left--;
        end
        else if (calm_mode || $urandom_range(0, 99) < 65)
            out_stall = 1'b0;
        else
        begin
            out_stall     = 1'b1;
            rx_burst_left = pick_gap() - 1;
        end
    end

    // Compare every accepted event beat with the oldest one still due.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_events.size() == 0)
                flag_mismatch("event with none due", '0, out_data);
            else
            begin
                next_due = due_events.pop_front();
                if (out_data.event_kind !== next_due.event_kind ||
                    out_data.event_mask !== next_due.event_mask ||
                    out_data.final_event !== next_due.final_event)
                    flag_mismatch("event differs", next_due, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        reset_predictor();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ordinary_chords();
        test_long_hold_combos();
        test_edge_values();
        test_random_phases();
        test_backpressure();

        wait_for_quiet();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
